>>> hw/rtl/robot_command_queue_decoder_top_assert.svh
// ----------------------------------------------------------------------------
// Robot command queue decoder: assertion macros
// Shared assertion wrappers for the port checker.
// ----------------------------------------------------------------------------
`ifndef ROBOT_COMMAND_QUEUE_DECODER_TOP_ASSERT_SVH
`define ROBOT_COMMAND_QUEUE_DECODER_TOP_ASSERT_SVH

// Checked only while out of reset.
`define RCQD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every edge, reset included.
`define RCQD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> hw/rtl/rcqd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Robot command queue decoder: package
// Shared types, codes and sizes for the front end, op queue and back end.
// ----------------------------------------------------------------------------
package rcqd_pkg;

  localparam int QUEUE_DEPTH = 24;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = 5;

  localparam int OPQ_DEPTH   = 2;
  localparam int OPQ_PTR_W   = $clog2(OPQ_DEPTH);
  localparam int OPQ_CNT_W   = $clog2(OPQ_DEPTH + 1);

  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SERVO_MAX   = 2'd2;

  localparam logic [15:0] PULSE_MS_RST    = 16'd220;
  localparam logic [6:0]  SPEED_LIMIT_RST = 7'd100;
  localparam logic [7:0]  SERVO_MAX_RST   = 8'd180;

  localparam logic [3:0] CMD_FWD       = 4'd0;
  localparam logic [3:0] CMD_BACK      = 4'd1;
  localparam logic [3:0] CMD_LEFT      = 4'd2;
  localparam logic [3:0] CMD_RIGHT     = 4'd3;
  localparam logic [3:0] CMD_PAN       = 4'd4;
  localparam logic [3:0] CMD_TILT      = 4'd5;
  localparam logic [3:0] CMD_LASER_ON  = 4'd6;
  localparam logic [3:0] CMD_LASER_OFF = 4'd7;
  localparam logic [3:0] CMD_STOP      = 4'd8;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_DRAIN = 2'd1,
    OP_CLEAR = 2'd2,
    OP_TICK  = 2'd3
  } op_kind_e;

  typedef enum logic [2:0] {
    ACT_NONE         = 3'd0,
    ACT_DRIVE        = 3'd1,
    ACT_PAN          = 3'd2,
    ACT_TILT         = 3'd3,
    ACT_LASER_ARM    = 3'd4,
    ACT_LASER_DISARM = 3'd5,
    ACT_STOP_ALL     = 3'd6
  } action_e;

  typedef struct packed {
    logic [3:0]         cmd_type;
    logic signed [15:0] cmd_param;
  } entry_t;

  typedef struct packed {
    op_kind_e kind;
    entry_t   cmd;
    logic     joy;
  } op_t;

  typedef struct packed {
    logic               last;
    logic               push_ok;
    logic [CNT_W-1:0]   queue_depth;
    action_e            action;
    logic [7:0]         servo_angle;
    logic               override_active;
    logic signed [7:0]  left_speed;
    logic signed [7:0]  right_speed;
  } res_t;

endpackage

>>> hw/rtl/rcqd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Robot command queue decoder: front end
// Registers incoming items and classifies the function code into an op.
// ----------------------------------------------------------------------------
module rcqd_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          func_i,
  input  logic [3:0]          cmd_type_i,
  input  logic signed [15:0]  cmd_param_i,
  input  logic                joystick_active_i,
  output logic                op_valid_o,
  input  logic                op_ready_i,
  output rcqd_pkg::op_t       op_o
);

  logic           valid_q, valid_d;
  rcqd_pkg::op_t  op_q, op_d;
  rcqd_pkg::op_kind_e kind;

  always_comb begin
    unique case (func_i)
      2'd0:    kind = rcqd_pkg::OP_PUSH;
      2'd1:    kind = rcqd_pkg::OP_DRAIN;
      2'd2:    kind = rcqd_pkg::OP_CLEAR;
      default: kind = rcqd_pkg::OP_TICK;
    endcase
  end

  assign in_ready_o = !valid_q || op_ready_i;

  always_comb begin
    valid_d = valid_q;
    op_d    = op_q;
    if (op_ready_i) begin
      valid_d = 1'b0;
    end
    if (in_valid_i && in_ready_o) begin
      valid_d            = 1'b1;
      op_d.kind          = kind;
      op_d.cmd.cmd_type  = cmd_type_i;
      op_d.cmd.cmd_param = cmd_param_i;
      op_d.joy           = joystick_active_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;
  end

  assign op_valid_o = valid_q;
  assign op_o       = op_q;

endmodule

>>> hw/rtl/rcqd_opq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Robot command queue decoder: op queue
// Short FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module rcqd_opq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_valid_i,
  output logic          wr_ready_o,
  input  rcqd_pkg::op_t wr_op_i,
  output logic          rd_valid_o,
  input  logic          rd_ready_i,
  output rcqd_pkg::op_t rd_op_o
);

  rcqd_pkg::op_t                    slot_q [rcqd_pkg::OPQ_DEPTH];
  logic [rcqd_pkg::OPQ_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [rcqd_pkg::OPQ_CNT_W-1:0]   cnt_q;
  logic                             push, pop;

  assign wr_ready_o = cnt_q != rcqd_pkg::OPQ_CNT_W'(rcqd_pkg::OPQ_DEPTH);
  assign rd_valid_o = cnt_q != '0;
  assign rd_op_o    = slot_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  function automatic logic [rcqd_pkg::OPQ_PTR_W-1:0] bump(
    input logic [rcqd_pkg::OPQ_PTR_W-1:0] p
  );
    return (p == rcqd_pkg::OPQ_PTR_W'(rcqd_pkg::OPQ_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= bump(wr_ptr_q);
      end
      if (pop) begin
        rd_ptr_q <= bump(rd_ptr_q);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= wr_op_i;
    end
  end

endmodule

>>> hw/rtl/rcqd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Robot command queue decoder: back end
// Ring buffer, drain sequencer, command decode, override state, result reg.
// ----------------------------------------------------------------------------
module rcqd_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rcqd_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [rcqd_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                op_valid_i,
  output logic                                op_ready_o,
  input  rcqd_pkg::op_t                       op_i,
  output logic                                res_valid_o,
  input  logic                                res_ready_i,
  output rcqd_pkg::res_t                      res_o
);

  typedef enum logic {S_IDLE, S_DRAIN} state_e;

  state_e                        state_q, state_d;
  logic [15:0]                   pulse_ms_q;
  logic [6:0]                    speed_limit_q;
  logic [7:0]                    servo_max_q;

  rcqd_pkg::entry_t              mem [rcqd_pkg::QUEUE_DEPTH];
  rcqd_pkg::entry_t              rdata_q;
  logic                          mem_we;

  logic [rcqd_pkg::PTR_W-1:0]    head_q, head_d, tail_q, tail_d;
  logic [rcqd_pkg::CNT_W-1:0]    fill_q, fill_d;
  logic signed [7:0]             left_q, left_d, right_q, right_d;
  logic [15:0]                   rem_q, rem_d;
  logic                          joy_q, joy_d, joy_sel;

  logic                          out_valid_q;
  rcqd_pkg::res_t                res_q, res_n;
  logic                          emit, emit_ok;

  // decode of the entry at the head
  logic signed [15:0]            p;
  logic [6:0]                    sp;
  logic signed [7:0]             sp_pos, sp_neg;
  logic                          head_ok;

  function automatic logic [rcqd_pkg::PTR_W-1:0] bump(
    input logic [rcqd_pkg::PTR_W-1:0] ptr
  );
    return (ptr == rcqd_pkg::PTR_W'(rcqd_pkg::QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;
  endfunction

  assign p = rdata_q.cmd_param;

  always_comb begin
    if (p[15]) begin
      sp = '0;
    end else if (p[14:0] > 15'(speed_limit_q)) begin
      sp = speed_limit_q;
    end else begin
      sp = p[6:0];
    end
  end

  assign sp_pos  = $signed({1'b0, sp});
  assign sp_neg  = -sp_pos;
  assign head_ok = !p[15] && (p[14:0] <= 15'(servo_max_q));

  assign emit_ok    = !out_valid_q || res_ready_i;
  assign op_ready_o = (state_q == S_IDLE) && emit_ok;
  assign joy_sel    = (state_q == S_IDLE) ? op_i.joy : joy_q;

  always_comb begin
    state_d = state_q;
    head_d  = head_q;
    tail_d  = tail_q;
    fill_d  = fill_q;
    left_d  = left_q;
    right_d = right_q;
    rem_d   = rem_q;
    joy_d   = joy_q;
    mem_we  = 1'b0;
    emit    = 1'b0;
    res_n   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (op_valid_i && op_ready_o) begin
          unique case (op_i.kind)
            rcqd_pkg::OP_PUSH: begin
              emit = 1'b1;
              res_n.last = 1'b1;
              if (fill_q < rcqd_pkg::CNT_W'(rcqd_pkg::QUEUE_DEPTH)) begin
                mem_we        = 1'b1;
                tail_d        = bump(tail_q);
                fill_d        = fill_q + 1'b1;
                res_n.push_ok = 1'b1;
              end
            end
            rcqd_pkg::OP_DRAIN: begin
              joy_d = op_i.joy;
              if (fill_q == '0) begin
                emit       = 1'b1;
                res_n.last = 1'b1;
              end else begin
                state_d = S_DRAIN;
              end
            end
            rcqd_pkg::OP_CLEAR: begin
              emit       = 1'b1;
              res_n.last = 1'b1;
              head_d     = '0;
              tail_d     = '0;
              fill_d     = '0;
            end
            default: begin
              emit       = 1'b1;
              res_n.last = 1'b1;
              if (rem_q != '0) begin
                rem_d = rem_q - 1'b1;
              end
            end
          endcase
        end
      end
      default: begin
        if (emit_ok) begin
          emit       = 1'b1;
          head_d     = bump(head_q);
          fill_d     = fill_q - 1'b1;
          res_n.last = (fill_q == rcqd_pkg::CNT_W'(1));
          if (res_n.last) begin
            state_d = S_IDLE;
          end
          unique case (rdata_q.cmd_type)
            rcqd_pkg::CMD_FWD, rcqd_pkg::CMD_BACK,
            rcqd_pkg::CMD_LEFT, rcqd_pkg::CMD_RIGHT: begin
              res_n.action = rcqd_pkg::ACT_DRIVE;
              left_d  = (rdata_q.cmd_type == rcqd_pkg::CMD_FWD ||
                         rdata_q.cmd_type == rcqd_pkg::CMD_RIGHT) ? sp_pos : sp_neg;
              right_d = (rdata_q.cmd_type == rcqd_pkg::CMD_FWD ||
                         rdata_q.cmd_type == rcqd_pkg::CMD_LEFT) ? sp_pos : sp_neg;
              rem_d   = pulse_ms_q;
            end
            rcqd_pkg::CMD_PAN, rcqd_pkg::CMD_TILT: begin
              if (head_ok) begin
                res_n.servo_angle = p[7:0];
                res_n.action = (rdata_q.cmd_type == rcqd_pkg::CMD_PAN) ?
                               rcqd_pkg::ACT_PAN : rcqd_pkg::ACT_TILT;
              end
            end
            rcqd_pkg::CMD_LASER_ON:  res_n.action = rcqd_pkg::ACT_LASER_ARM;
            rcqd_pkg::CMD_LASER_OFF: res_n.action = rcqd_pkg::ACT_LASER_DISARM;
            rcqd_pkg::CMD_STOP:      res_n.action = rcqd_pkg::ACT_STOP_ALL;
            default:                 res_n.action = rcqd_pkg::ACT_NONE;
          endcase
        end
      end
    endcase

    // override fields show the state after this result
    res_n.queue_depth     = fill_d;
    res_n.override_active = (rem_d != '0) && !joy_sel;
    res_n.left_speed      = res_n.override_active ? left_d  : '0;
    res_n.right_speed     = res_n.override_active ? right_d : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      pulse_ms_q    <= rcqd_pkg::PULSE_MS_RST;
      speed_limit_q <= rcqd_pkg::SPEED_LIMIT_RST;
      servo_max_q   <= rcqd_pkg::SERVO_MAX_RST;
      head_q        <= '0;
      tail_q        <= '0;
      fill_q        <= '0;
      left_q        <= '0;
      right_q       <= '0;
      rem_q         <= '0;
      joy_q         <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      fill_q  <= fill_d;
      left_q  <= left_d;
      right_q <= right_d;
      rem_q   <= rem_d;
      joy_q   <= joy_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          rcqd_pkg::CFG_PULSE_MS:    pulse_ms_q    <= cfg_data_i;
          rcqd_pkg::CFG_SPEED_LIMIT: speed_limit_q <= cfg_data_i[6:0];
          rcqd_pkg::CFG_SERVO_MAX:   servo_max_q   <= cfg_data_i[7:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_q <= res_n;
    end
  end

  // ring buffer: read data follows the next head so a drain runs one per cycle when the output is not stalled
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[tail_q] <= op_i.cmd;
    end
    rdata_q <= mem[head_d];
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

>>> hw/rtl/robot_command_queue_decoder_top.sv
// Push, clear, tick and empty drain pass the front-end register, the op queue and the result
// register. A drain of n entries gives one result per cycle while the output is not stalled.
// Throughput: one single-result item per cycle when not stalled; a drain holds the back end
// for all n reads of its one-port entry store. Up to 2 items wait in the op queue.
// Reset: asynchronous active low; pointers, countdown and overrides clear, registers reload.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Robot command queue decoder: top level
// Command FIFO with decoder; front end, op queue and back end.
// ----------------------------------------------------------------------------
module robot_command_queue_decoder_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [rcqd_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [rcqd_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [1:0]                       func_i,
  input  logic [3:0]                       cmd_type_i,
  input  logic signed [15:0]               cmd_param_i,
  input  logic                             joystick_active_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             last_o,
  output logic                             push_ok_o,
  output logic [4:0]                       queue_depth_o,
  output logic [2:0]                       action_o,
  output logic [7:0]                       servo_angle_o,
  output logic                             override_active_o,
  output logic signed [7:0]                left_speed_o,
  output logic signed [7:0]                right_speed_o
);

  logic           f_valid, f_ready, q_valid, q_ready;
  rcqd_pkg::op_t  f_op, q_op;
  rcqd_pkg::res_t res;

  rcqd_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .func_i            (func_i),
    .cmd_type_i        (cmd_type_i),
    .cmd_param_i       (cmd_param_i),
    .joystick_active_i (joystick_active_i),
    .op_valid_o        (f_valid),
    .op_ready_i        (f_ready),
    .op_o              (f_op)
  );

  rcqd_opq u_opq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (f_valid),
    .wr_ready_o (f_ready),
    .wr_op_i    (f_op),
    .rd_valid_o (q_valid),
    .rd_ready_i (q_ready),
    .rd_op_o    (q_op)
  );

  rcqd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .op_valid_i  (q_valid),
    .op_ready_o  (q_ready),
    .op_i        (q_op),
    .res_valid_o (out_valid_o),
    .res_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign last_o            = res.last;
  assign push_ok_o         = res.push_ok;
  assign queue_depth_o     = res.queue_depth;
  assign action_o          = res.action;
  assign servo_angle_o     = res.servo_angle;
  assign override_active_o = res.override_active;
  assign left_speed_o      = res.left_speed;
  assign right_speed_o     = res.right_speed;

endmodule

>>> hw/rtl/rcqd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Robot command queue decoder: port checker
// Watches the top-level ports for result consistency over time.
// ----------------------------------------------------------------------------
`include "robot_command_queue_decoder_top_assert.svh"

module rcqd_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input logic                             last_o,
  input logic                             push_ok_o,
  input logic [4:0]                       queue_depth_o,
  input logic [2:0]                       action_o,
  input logic [7:0]                       servo_angle_o,
  input logic                             override_active_o,
  input logic signed [7:0]                left_speed_o,
  input logic signed [7:0]                right_speed_o
);

  // stalled result holds its valid, last, action, depth and left speed
  `RCQD_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(last_o) && $stable(action_o) && $stable(queue_depth_o) && $stable(left_speed_o), "result changed while stalled")

  // a stored push is a single result with no action
  `RCQD_ASSERT(a_push_single, out_valid_o && push_ok_o |-> last_o && action_o == rcqd_pkg::ACT_NONE, "push result carries action")

  // speeds are zeroed whenever the override is off
  `RCQD_ASSERT(a_speed_gate, out_valid_o && !override_active_o |-> left_speed_o == 8'sd0 && right_speed_o == 8'sd0, "speed shown without override")

  // only head actions carry an angle
  `RCQD_ASSERT(a_angle_head, out_valid_o && servo_angle_o != 8'd0 |-> action_o == rcqd_pkg::ACT_PAN || action_o == rcqd_pkg::ACT_TILT, "angle on non-head action")

  `RCQD_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !out_valid_o, "result valid in reset")

endmodule

bind robot_command_queue_decoder_top rcqd_checker u_rcqd_checker (.*);

>>> dv/rcqd_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Robot command queue decoder: result checker
// Watches the config port and both channels, keeps its own copy of the
// command ring, the wheel overrides and the countdown, queues the results
// each accepted op should give, and compares every output transfer with
// the oldest queued result, field by field.
// ----------------------------------------------------------------------------
module rcqd_result_checker
  import rcqd_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   in_valid_i,
  input  logic                   in_ready_i,
  input  logic [1:0]             func_i,
  input  logic [3:0]             cmd_type_i,
  input  logic signed [15:0]     cmd_param_i,
  input  logic                   joystick_active_i,
  input  logic                   out_valid_i,
  input  logic                   out_ready_i,
  input  logic                   last_i,
  input  logic                   push_ok_i,
  input  logic [4:0]             queue_depth_i,
  input  logic [2:0]             action_i,
  input  logic [7:0]             servo_angle_i,
  input  logic                   override_active_i,
  input  logic signed [7:0]      left_speed_i,
  input  logic signed [7:0]      right_speed_i,
  output int                     outstanding_o,
  output int                     mismatch_count_o
);

  logic [15:0]       pulse_ms_q;
  logic [6:0]        speed_limit_q;
  logic [7:0]        servo_max_q;

  entry_t            ring_q [QUEUE_DEPTH];
  int                rd_idx;
  int                wr_idx;
  logic [CNT_W-1:0]  fill_q;
  logic signed [7:0] left_q;
  logic signed [7:0] right_q;
  logic [15:0]       countdown_q;

  res_t              queued_results[$];
  int                err_cnt = 0;

  function automatic void reset_model();
    pulse_ms_q    = PULSE_MS_RST;
    speed_limit_q = SPEED_LIMIT_RST;
    servo_max_q   = SERVO_MAX_RST;
    rd_idx        = 0;
    wr_idx        = 0;
    fill_q        = '0;
    left_q        = '0;
    right_q       = '0;
    countdown_q   = '0;
    queued_results.delete();
  endfunction

  // Override fields follow the state as it stands when the result is formed.
  function automatic res_t make_result(logic ok, action_e act, logic [7:0] angle, logic joy);
    res_t r;
    logic on;
    on                = (countdown_q != 16'd0) && !joy;
    r.last            = 1'b0;
    r.push_ok         = ok;
    r.queue_depth     = fill_q;
    r.action          = act;
    r.servo_angle     = angle;
    r.override_active = on;
    r.left_speed      = on ? left_q : 8'sd0;
    r.right_speed     = on ? right_q : 8'sd0;
    return r;
  endfunction

  function automatic action_e decode_entry(entry_t e, output logic [7:0] angle);
    int p;
    int sp;
    int lv;
    int rv;
    p     = $signed(e.cmd_param);
    sp    = (p < 0) ? 0 : p;
    angle = 8'd0;
    if (sp > int'(speed_limit_q)) sp = int'(speed_limit_q);
    case (e.cmd_type)
      CMD_FWD, CMD_BACK, CMD_LEFT, CMD_RIGHT: begin
        lv          = (e.cmd_type == CMD_FWD || e.cmd_type == CMD_RIGHT) ? sp : -sp;
        rv          = (e.cmd_type == CMD_FWD || e.cmd_type == CMD_LEFT) ? sp : -sp;
        left_q      = lv[7:0];
        right_q     = rv[7:0];
        countdown_q = pulse_ms_q;
        return ACT_DRIVE;
      end
      CMD_PAN, CMD_TILT: begin
        // out-of-range angle gives no action at all
        if (p >= 0 && p <= int'(servo_max_q)) begin
          angle = p[7:0];
          return (e.cmd_type == CMD_PAN) ? ACT_PAN : ACT_TILT;
        end
        return ACT_NONE;
      end
      CMD_LASER_ON:  return ACT_LASER_ARM;
      CMD_LASER_OFF: return ACT_LASER_DISARM;
      CMD_STOP:      return ACT_STOP_ALL;
      default:       return ACT_NONE;
    endcase
  endfunction

  task automatic predict_op(input op_kind_e op, input logic [3:0] ty,
                            input logic signed [15:0] prm, input logic joy);
    entry_t     e;
    action_e    act;
    logic [7:0] ang;
    logic       ok;
    int         first;
    res_t       tail;
    first = queued_results.size();
    case (op)
      OP_PUSH: begin
        ok = 1'b0;
        if (fill_q < QUEUE_DEPTH) begin
          ring_q[wr_idx] = {ty, prm};
          wr_idx         = (wr_idx + 1) % QUEUE_DEPTH;
          fill_q++;
          ok = 1'b1;
        end
        queued_results.push_back(make_result(ok, ACT_NONE, 8'd0, joy));
      end
      OP_DRAIN: begin
        while (fill_q != 0) begin
          e      = ring_q[rd_idx];
          rd_idx = (rd_idx + 1) % QUEUE_DEPTH;
          fill_q--;
          act = decode_entry(e, ang);
          queued_results.push_back(make_result(1'b0, act, ang, joy));
        end
        if (queued_results.size() == first)
          queued_results.push_back(make_result(1'b0, ACT_NONE, 8'd0, joy));
      end
      OP_CLEAR: begin
        rd_idx = 0;
        wr_idx = 0;
        fill_q = '0;
        queued_results.push_back(make_result(1'b0, ACT_NONE, 8'd0, joy));
      end
      default: begin
        if (countdown_q != 16'd0) countdown_q--;
        queued_results.push_back(make_result(1'b0, ACT_NONE, 8'd0, joy));
      end
    endcase
    tail      = queued_results[queued_results.size()-1];
    tail.last = 1'b1;
    queued_results[queued_results.size()-1] = tail;
  endtask

  function automatic int field_diff(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch: expected %0h actual %0h", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  task automatic check_result(input res_t got);
    res_t want;
    int   bad;
    if (queued_results.size() == 0) begin
      $display("%0t ns: result with none outstanding: expected nothing actual %h", $time, got);
      err_cnt++;
    end else begin
      want = queued_results.pop_front();
      bad  = 0;
      bad += field_diff("last", want.last, got.last);
      bad += field_diff("push_ok", want.push_ok, got.push_ok);
      bad += field_diff("queue_depth", want.queue_depth, got.queue_depth);
      bad += field_diff("action", want.action, got.action);
      bad += field_diff("servo_angle", want.servo_angle, got.servo_angle);
      bad += field_diff("override_active", want.override_active, got.override_active);
      bad += field_diff("left_speed", want.left_speed, got.left_speed);
      bad += field_diff("right_speed", want.right_speed, got.right_speed);
      if (bad != 0) err_cnt++;
    end
  endtask

  // Config, then the input transfer, then the output transfer: a result
  // never belongs to an op accepted on the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reset_model();
      outstanding_o    <= 0;
      mismatch_count_o <= err_cnt;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_PULSE_MS:    pulse_ms_q    = cfg_data_i;
          CFG_SPEED_LIMIT: speed_limit_q = cfg_data_i[6:0];
          CFG_SERVO_MAX:   servo_max_q   = cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i)
        predict_op(op_kind_e'(func_i), cmd_type_i, cmd_param_i, joystick_active_i);
      if (out_valid_i && out_ready_i)
        check_result({last_i, push_ok_i, queue_depth_i, action_i, servo_angle_i,
                      override_active_i, left_speed_i, right_speed_i});
      outstanding_o    <= queued_results.size();
      mismatch_count_o <= err_cnt;
    end
  end

endmodule

>>> dv/tb_robot_command_queue_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Robot command queue decoder: testbench top
// Drives a directed op sequence and several random phases under different
// register settings, with bursty input, a patterned output stall and one long
// output hold-off; the result checker beside the block does the comparing.
// ----------------------------------------------------------------------------
module tb_robot_command_queue_decoder_top;
  import rcqd_pkg::*;

  localparam int         HOLD_CYCLES   = 400;
  localparam int         PROFILE_MIXED = 0;
  localparam int         PROFILE_FILL  = 1;
  localparam logic [3:0] CMD_UNUSED_LO = 4'd9;
  localparam logic [3:0] CMD_UNUSED_HI = 4'd15;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_index_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;
  logic                   in_valid_i;
  logic                   in_ready_o;
  logic [1:0]             func_i;
  logic [3:0]             cmd_type_i;
  logic signed [15:0]     cmd_param_i;
  logic                   joystick_active_i;
  logic                   out_valid_o;
  logic                   out_ready_i;
  logic                   last_o;
  logic                   push_ok_o;
  logic [4:0]             queue_depth_o;
  logic [2:0]             action_o;
  logic [7:0]             servo_angle_o;
  logic                   override_active_o;
  logic signed [7:0]      left_speed_o;
  logic signed [7:0]      right_speed_o;

  int                     outstanding;
  int                     mismatches;
  logic                   hold_req;
  logic                   hold_done;
  int                     burst_left;
  logic [6:0]             cur_limit;
  logic [7:0]             cur_smax;

  robot_command_queue_decoder_top i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .func_i            (func_i),
    .cmd_type_i        (cmd_type_i),
    .cmd_param_i       (cmd_param_i),
    .joystick_active_i (joystick_active_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .last_o            (last_o),
    .push_ok_o         (push_ok_o),
    .queue_depth_o     (queue_depth_o),
    .action_o          (action_o),
    .servo_angle_o     (servo_angle_o),
    .override_active_o (override_active_o),
    .left_speed_o      (left_speed_o),
    .right_speed_o     (right_speed_o)
  );

  rcqd_result_checker i_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_i        (in_ready_o),
    .func_i            (func_i),
    .cmd_type_i        (cmd_type_i),
    .cmd_param_i       (cmd_param_i),
    .joystick_active_i (joystick_active_i),
    .out_valid_i       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .last_i            (last_o),
    .push_ok_i         (push_ok_o),
    .queue_depth_i     (queue_depth_o),
    .action_i          (action_o),
    .servo_angle_i     (servo_angle_o),
    .override_active_i (override_active_o),
    .left_speed_i      (left_speed_o),
    .right_speed_i     (right_speed_o),
    .outstanding_o     (outstanding),
    .mismatch_count_o  (mismatches)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #6_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Output side: stall pattern changes every segment; one long hold-off
  // once the stimulus asks for it.
  initial begin : sink_side
    int mode;
    int seg;
    out_ready_i <= 1'b0;
    hold_done   <= 1'b0;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(0, 3);
      seg  = $urandom_range(4, 80);
      repeat (seg) begin
        @(posedge clk_i);
        if (hold_req && !hold_done) begin
          out_ready_i <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk_i);
          hold_done <= 1'b1;
        end
        case (mode)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= $urandom_range(0, 1);
          2:       out_ready_i <= ($urandom_range(0, 4) == 0);
          default: out_ready_i <= ($urandom_range(0, 4) != 0);
        endcase
      end
    end
  end

  // Returns right after the edge that carried the transfer.
  task automatic send_item(input op_kind_e op, input logic [3:0] ty,
                           input logic signed [15:0] prm, input logic joy);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 8);
    end
    burst_left--;
    in_valid_i        <= 1'b1;
    func_i            <= op;
    cmd_type_i        <= ty;
    cmd_param_i       <= prm;
    joystick_active_i <= joy;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [15:0] pulse, input logic [6:0] lim,
                              input logic [7:0] smax);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_PULSE_MS;
    cfg_data_i  <= pulse;
    @(posedge clk_i);
    cfg_index_i <= CFG_SPEED_LIMIT;
    cfg_data_i  <= {9'd0, lim};
    @(posedge clk_i);
    cfg_index_i <= CFG_SERVO_MAX;
    cfg_data_i  <= {8'd0, smax};
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_limit = lim;
    cur_smax  = smax;
  endtask

  task automatic send_random(input int profile);
    op_kind_e           op;
    logic [3:0]         ty;
    logic signed [15:0] prm;
    int                 r;
    int                 bound;
    r = $urandom_range(0, 99);
    if (profile == PROFILE_FILL)
      op = (r < 90) ? OP_PUSH : (r < 94) ? OP_DRAIN : (r < 97) ? OP_TICK : OP_CLEAR;
    else
      op = (r < 55) ? OP_PUSH : (r < 72) ? OP_DRAIN : (r < 93) ? OP_TICK : OP_CLEAR;
    if ($urandom_range(0, 9) == 0)
      ty = 4'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
    else
      ty = 4'($urandom_range(CMD_FWD, CMD_STOP));
    // three in eight params fall from zero to 12 past the clamp or the angle bound
    bound = (ty == CMD_PAN || ty == CMD_TILT) ? int'(cur_smax) : int'(cur_limit);
    case ($urandom_range(0, 7))
      0:       prm = 16'sh8000;
      1:       prm = 16'sh7fff;
      2, 3:    prm = 16'($urandom);
      4:       prm = 16'(-$urandom_range(1, 40));
      default: prm = 16'($urandom_range(0, bound + 12));
    endcase
    send_item(op, ty, prm, $urandom_range(0, 3) == 0);
  endtask

  task automatic run_phase(input int n, input int profile);
    repeat (n) send_random(profile);
  endtask

  initial begin : stimulus
    rst_ni            <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_index_i       <= CFG_PULSE_MS;
    cfg_data_i        <= '0;
    in_valid_i        <= 1'b0;
    func_i            <= OP_PUSH;
    cmd_type_i        <= CMD_FWD;
    cmd_param_i       <= '0;
    joystick_active_i <= 1'b0;
    hold_req          <= 1'b0;
    burst_left = 0;
    cur_limit  = SPEED_LIMIT_RST;
    cur_smax   = SERVO_MAX_RST;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty queue cases, every command, clamps, angle bounds
    send_item(OP_DRAIN, CMD_FWD, 16'sd0, 1'b0);
    send_item(OP_TICK, CMD_FWD, 16'sd0, 1'b0);
    send_item(OP_CLEAR, CMD_FWD, 16'sd0, 1'b0);
    send_item(OP_PUSH, CMD_FWD, 16'sd50, 1'b0);
    send_item(OP_PUSH, CMD_BACK, -16'sd5, 1'b0);
    send_item(OP_PUSH, CMD_LEFT, 16'sh7fff, 1'b0);
    send_item(OP_PUSH, CMD_RIGHT, 16'sd100, 1'b1);
    send_item(OP_PUSH, CMD_PAN, 16'sd0, 1'b0);
    send_item(OP_PUSH, CMD_TILT, 16'sd180, 1'b0);
    send_item(OP_PUSH, CMD_PAN, 16'sd181, 1'b0);
    send_item(OP_PUSH, CMD_TILT, 16'sh8000, 1'b0);
    send_item(OP_PUSH, CMD_LASER_ON, 16'sd0, 1'b0);
    send_item(OP_PUSH, CMD_LASER_OFF, 16'sd0, 1'b0);
    send_item(OP_PUSH, CMD_STOP, 16'sd0, 1'b0);
    send_item(OP_PUSH, CMD_UNUSED_HI, 16'sh7fff, 1'b0);
    send_item(OP_PUSH, CMD_UNUSED_LO, -16'sd1, 1'b0);
    send_item(OP_DRAIN, CMD_FWD, 16'sd0, 1'b0);
    send_item(OP_TICK, CMD_FWD, 16'sd0, 1'b1);
    send_item(OP_TICK, CMD_FWD, 16'sd0, 1'b0);
    send_item(OP_PUSH, CMD_FWD, 16'sd120, 1'b0);
    send_item(OP_PUSH, CMD_PAN, 16'sd90, 1'b0);
    send_item(OP_CLEAR, CMD_FWD, 16'sd0, 1'b0);
    send_item(OP_DRAIN, CMD_FWD, 16'sd0, 1'b0);
    send_item(OP_PUSH, CMD_STOP, 16'sd0, 1'b0);
    send_item(OP_DRAIN, CMD_FWD, 16'sd0, 1'b1);

    // push-heavy with the long output hold-off: queue fills and drops,
    // input side backs up
    program_regs(16'd1, 7'd0, 8'd0);
    hold_req <= 1'b1;
    run_phase(60, PROFILE_FILL);

    program_regs(16'hffff, 7'd127, 8'd255);
    run_phase(60, PROFILE_MIXED);

    // zero pulse: drive sets speeds, override never turns on
    program_regs(16'd0, 7'd50, 8'd90);
    run_phase(50, PROFILE_MIXED);

    program_regs(16'd3, 7'd127, 8'd0);
    run_phase(60, PROFILE_MIXED);

    program_regs(16'($urandom_range(1, 8)), 7'($urandom), 8'($urandom));
    run_phase(60, PROFILE_FILL);

    program_regs(PULSE_MS_RST, SPEED_LIMIT_RST, SERVO_MAX_RST);
    run_phase(60, PROFILE_MIXED);

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
